// File: rtl/core/bpuck_pkg.sv
`default_nettype none
package bpuck_pkg;

  // largest image side the counters are built for
  localparam int MAX_DIMENSION_DEF = 4096;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_REG_W  = 13;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam int COLOR_W     = 8;
  localparam int PIX_INDEX_W = 24;

  localparam logic [COLOR_W-1:0] COLOR_FULL   = 8'hFF;
  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [COLOR_W-1:0] ALPHA_KEY    = 8'h00;

  localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

// File: rtl/core/bpuck_if.sv
`default_nettype none
interface bpuck_in_if;
  logic                            valid;
  logic                            ready;
  logic [bpuck_pkg::COLOR_W-1:0]   data_byte;
  logic                            frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface bpuck_out_if;
  logic                              valid;
  logic                              ready;
  logic [bpuck_pkg::COLOR_W-1:0]     red;
  logic [bpuck_pkg::COLOR_W-1:0]     green;
  logic [bpuck_pkg::COLOR_W-1:0]     blue;
  logic [bpuck_pkg::COLOR_W-1:0]     alpha;
  logic [bpuck_pkg::PIX_INDEX_W-1:0] pixel_index;
  logic                              last_pixel;

  modport source (output valid, red, green, blue, alpha, pixel_index, last_pixel,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, pixel_index, last_pixel,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/bpuck_front.sv
`default_nettype none
module bpuck_front #(
  parameter int  DIM_W = 13,
  parameter int  CNT_W = 12,
  parameter type pix_t = logic
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bpuck_in_if.sink              in_ch,
  input  wire logic [DIM_W-1:0] width_i,
  input  wire logic [DIM_W-1:0] height_i,
  input  wire logic             q_full_i,
  output      logic             push_o,
  output      pix_t             item_o
);

  localparam int CMP_W = DIM_W + 1;

  typedef enum logic [1:0] {PH_BLUE, PH_GREEN, PH_RED} phase_t;

  phase_t                          phase_r, phase_nxt, phase_eff;
  logic [CNT_W-1:0]                col_r, col_nxt, col_eff;
  logic [CNT_W-1:0]                row_r, row_nxt, row_eff;
  logic [1:0]                      pad_r, pad_nxt, pad_eff;
  logic [bpuck_pkg::COLOR_W-1:0]   blue_r, blue_nxt, green_r, green_nxt;
  logic                            accept;
  logic                            row_end, frame_end;

  assign in_ch.ready = !q_full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // frame_start clears the counters before the byte is used
  assign phase_eff = in_ch.frame_start ? PH_BLUE : phase_r;
  assign col_eff   = in_ch.frame_start ? '0 : col_r;
  assign row_eff   = in_ch.frame_start ? '0 : row_r;
  assign pad_eff   = in_ch.frame_start ? '0 : pad_r;

  assign row_end   = (CMP_W'(col_eff) + CMP_W'(1)) >= CMP_W'(width_i);
  assign frame_end = (CMP_W'(row_eff) + CMP_W'(1)) >= CMP_W'(height_i);

  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pad_nxt   = pad_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    push_o    = 1'b0;
    if (accept) begin
      phase_nxt = phase_eff;
      col_nxt   = col_eff;
      row_nxt   = row_eff;
      pad_nxt   = pad_eff;
      if (pad_eff != 2'd0) begin
        pad_nxt = pad_eff - 2'd1;
      end else begin
        unique case (phase_eff)
          PH_GREEN: begin
            green_nxt = in_ch.data_byte;
            phase_nxt = PH_RED;
          end
          PH_RED: begin
            push_o    = 1'b1;
            phase_nxt = PH_BLUE;
            if (row_end) begin
              col_nxt = '0;
              pad_nxt = width_i[1:0];
              row_nxt = frame_end ? '0 : row_eff + CNT_W'(1);
            end else begin
              col_nxt = col_eff + CNT_W'(1);
            end
          end
          default: begin
            blue_nxt  = in_ch.data_byte;
            phase_nxt = PH_GREEN;
          end
        endcase
      end
    end
  end

  always_comb begin
    item_o       = '0;
    item_o.red   = in_ch.data_byte;
    item_o.green = green_r;
    item_o.blue  = blue_r;
    item_o.row   = row_eff;
    item_o.col   = col_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLUE;
      col_r   <= '0;
      row_r   <= '0;
      pad_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pad_r   <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
  end

  // padding is only ever counted between pixels
  a_pad_between_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (pad_r != 2'd0) |-> (phase_r == PH_BLUE))
    else $error("padding pending inside a pixel");

endmodule
`default_nettype wire

// File: rtl/core/bpuck_queue.sv
`default_nettype none
module bpuck_queue #(
  parameter int  DEPTH  = 4,
  parameter type item_t = logic
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output      item_t item_o,
  output      logic  full_o,
  output      logic  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign item_o  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && empty_o))
    else $error("queue read while empty");

endmodule
`default_nettype wire

// File: rtl/core/bpuck_back.sv
`default_nettype none
module bpuck_back #(
  parameter int  DIM_W = 13,
  parameter int  CNT_W = 12,
  parameter type pix_t = logic
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [DIM_W-1:0] width_i,
  input  wire logic [DIM_W-1:0] height_i,
  input  wire logic             q_empty_i,
  input  wire pix_t             item_i,
  output      logic             pop_o,
  bpuck_out_if.source           out_ch
);

  localparam int IDX_W  = bpuck_pkg::PIX_INDEX_W;
  localparam int PROD_W = 2 * DIM_W;
  localparam int SUM_W  = (PROD_W + 1 > IDX_W) ? PROD_W + 1 : IDX_W;
  localparam int CMP_W  = DIM_W + 1;

  logic [DIM_W-1:0]                 h_last, row_c, flipped;
  logic [PROD_W-1:0]                prod;
  logic [SUM_W-1:0]                 sum;
  logic                             last, keyed;

  logic                             out_valid_r;
  logic [bpuck_pkg::COLOR_W-1:0]    red_r, green_r, blue_r, alpha_r;
  logic [IDX_W-1:0]                 index_r;
  logic                             last_r;

  assign pop_o = !q_empty_i && (!out_valid_r || out_ch.ready);

  // rows past a shrunken height map onto the top row
  assign h_last  = height_i - DIM_W'(1);
  assign row_c   = (DIM_W'(item_i.row) > h_last) ? h_last : DIM_W'(item_i.row);
  assign flipped = h_last - row_c;
  assign prod    = PROD_W'(flipped) * PROD_W'(width_i);
  assign sum     = SUM_W'(prod) + SUM_W'(item_i.col);
  assign last    = (row_c == h_last) &&
                   ((CMP_W'(item_i.col) + CMP_W'(1)) >= CMP_W'(width_i));
  assign keyed   = (item_i.red == bpuck_pkg::COLOR_FULL) &&
                   (item_i.green == bpuck_pkg::COLOR_FULL) &&
                   (item_i.blue == bpuck_pkg::COLOR_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_o) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      red_r   <= item_i.red;
      green_r <= item_i.green;
      blue_r  <= item_i.blue;
      alpha_r <= keyed ? bpuck_pkg::ALPHA_KEY : bpuck_pkg::ALPHA_OPAQUE;
      index_r <= sum[IDX_W-1:0];
      last_r  <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red         = red_r;
  assign out_ch.green       = green_r;
  assign out_ch.blue        = blue_r;
  assign out_ch.alpha       = alpha_r;
  assign out_ch.pixel_index = index_r;
  assign out_ch.last_pixel  = last_r;

  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |=> out_valid_r)
    else $error("popped pixel did not reach the output register");

endmodule
`default_nettype wire

// File: rtl/core/bmp24_pixel_unpack_color_key_top.sv
// Path: each completed pixel goes into the queue, then into the output register once that is free.
// Throughput: one byte per cycle if the queue is not full, one pixel per three color bytes.
// The rate is set by the front byte counter and the single-pixel back stage (one multiply-add).
// A four-entry queue between front and back absorbs output stalls.
// Reset (rst_n low, synchronous): counters, phase, queue and output valid clear;
// image size returns to 640 x 480.
`default_nettype none
module bmp24_pixel_unpack_color_key_top #(
  parameter int MAX_DIMENSION = bpuck_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bpuck_in_if.sink                              in_ch,
  bpuck_out_if.source                           out_ch,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [bpuck_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [bpuck_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [bpuck_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output      logic                             cfg_pready
);

  localparam int REG_W = bpuck_pkg::CFG_REG_W;
  // stored size: holds 1..min(MAX_DIMENSION, 8191)
  localparam int DIM_W = ($clog2(MAX_DIMENSION + 1) < REG_W) ?
                         $clog2(MAX_DIMENSION + 1) : REG_W;
  // counters: hold 0..size-1
  localparam int CNT_W = ($clog2(MAX_DIMENSION) < REG_W) ? $clog2(MAX_DIMENSION) : REG_W;
  localparam int W_RST = (bpuck_pkg::WIDTH_RESET > MAX_DIMENSION) ?
                         MAX_DIMENSION : bpuck_pkg::WIDTH_RESET;
  localparam int H_RST = (bpuck_pkg::HEIGHT_RESET > MAX_DIMENSION) ?
                         MAX_DIMENSION : bpuck_pkg::HEIGHT_RESET;

  // one pixel handed from front to back
  typedef struct packed {
    logic [bpuck_pkg::COLOR_W-1:0] red;
    logic [bpuck_pkg::COLOR_W-1:0] green;
    logic [bpuck_pkg::COLOR_W-1:0] blue;
    logic [CNT_W-1:0]              row;
    logic [CNT_W-1:0]              col;
  } pix_t;

  logic [DIM_W-1:0] width_r, height_r, clamped;
  logic [REG_W-1:0] wr_val;
  logic             cfg_wr;

  pix_t             push_item, pop_item;
  logic             push, pop, q_full, q_empty;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_val     = cfg_pwdata[REG_W-1:0];

  // zero is taken as one, oversize as the largest supported side
  always_comb begin
    if (wr_val == '0) begin
      clamped = DIM_W'(1);
    end else if (32'(wr_val) > 32'(MAX_DIMENSION)) begin
      clamped = DIM_W'(MAX_DIMENSION);
    end else begin
      clamped = DIM_W'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(W_RST);
      height_r <= DIM_W'(H_RST);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        bpuck_pkg::REG_IMAGE_WIDTH:  width_r  <= clamped;
        bpuck_pkg::REG_IMAGE_HEIGHT: height_r <= clamped;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      bpuck_pkg::REG_IMAGE_WIDTH:  cfg_prdata = bpuck_pkg::CFG_DATA_W'(width_r);
      bpuck_pkg::REG_IMAGE_HEIGHT: cfg_prdata = bpuck_pkg::CFG_DATA_W'(height_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------- front: byte phase, padding, row/column counters ----------------
  bpuck_front #(
    .DIM_W (DIM_W),
    .CNT_W (CNT_W),
    .pix_t (pix_t)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .width_i  (width_r),
    .height_i (height_r),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  // ---------------- pixel queue ----------------
  bpuck_queue #(
    .DEPTH  (bpuck_pkg::QUEUE_DEPTH),
    .item_t (pix_t)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // ---------------- back: row flip, index, color key, output register ----------------
  bpuck_back #(
    .DIM_W (DIM_W),
    .CNT_W (CNT_W),
    .pix_t (pix_t)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .width_i   (width_r),
    .height_i  (height_r),
    .q_empty_i (q_empty),
    .item_i    (pop_item),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
